// ----- rtl/hpq_pkg.sv -----
// ----------------------------------------------------------------------------
// Heap priority queue package
// Shared types, field widths and operation and status codes.
// ----------------------------------------------------------------------------
package hpq_pkg;

	localparam int KEY_W        = 32;
	localparam int OP_W         = 2;
	localparam int STATUS_W     = 2;
	localparam int COUNT_W      = 7;
	localparam int DEF_CAPACITY = 64;

	typedef logic signed [KEY_W-1:0] key_t;
	typedef logic [OP_W-1:0]         op_t;
	typedef logic [STATUS_W-1:0]     status_t;
	typedef logic [COUNT_W-1:0]      count_t;

	// Operation codes. The fourth code is a no-op.
	localparam op_t OP_INSERT  = 2'd0;
	localparam op_t OP_REMOVE  = 2'd1;
	localparam op_t OP_EXTRACT = 2'd2;

	// Status codes.
	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_NOT_FOUND = 2'd1;
	localparam status_t ST_EMPTY     = 2'd2;
	localparam status_t ST_FULL      = 2'd3;

	// Top value reported when nothing is extracted.
	localparam key_t NO_TOP = -32'sd1;

endpackage

// ----- rtl/hpq_req_if.sv -----
// ----------------------------------------------------------------------------
// Heap priority queue request channel
// Valid/ready channel carrying one operation word.
// ----------------------------------------------------------------------------
interface hpq_req_if;

	logic          valid;
	logic          ready;
	hpq_pkg::op_t  op;
	hpq_pkg::key_t key;

	modport source (output valid, output op, output key, input ready);
	modport sink   (input valid, input op, input key, output ready);

endinterface

// ----- rtl/hpq_rsp_if.sv -----
// ----------------------------------------------------------------------------
// Heap priority queue response channel
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
interface hpq_rsp_if;

	logic             valid;
	logic             ready;
	hpq_pkg::key_t    top_value;
	hpq_pkg::status_t status;
	hpq_pkg::count_t  entry_count;
	logic             is_empty;

	modport source (output valid, output top_value, output status, output entry_count,
		output is_empty, input ready);
	modport sink   (input valid, input top_value, input status, input entry_count,
		input is_empty, output ready);

endinterface

// ----- rtl/hpq_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and two read ports with registered read data.
// ----------------------------------------------------------------------------
module hpq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en_a,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
	output logic [WIDTH-1:0]         rd_data_a,
	input  logic                     rd_en_b,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
	output logic [WIDTH-1:0]         rd_data_b
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_a_q;
	logic [WIDTH-1:0] rd_b_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en_a) begin
			rd_a_q <= mem[rd_addr_a];
		end
		if (rd_en_b) begin
			rd_b_q <= mem[rd_addr_b];
		end
	end

	assign rd_data_a = rd_a_q;
	assign rd_data_b = rd_b_q;

endmodule

// ----- rtl/hpq_cmp.sv -----
// ----------------------------------------------------------------------------
// Heap key comparator
// Signed greater-than and equality of two keys, shared by every compare step.
// ----------------------------------------------------------------------------
module hpq_cmp (
	input  hpq_pkg::key_t a,
	input  hpq_pkg::key_t b,
	output logic          gt,
	output logic          eq
);

	import hpq_pkg::*;

	assign gt = (a > b);
	assign eq = (a == b);

endmodule

// ----- rtl/max_heap_priority_queue.sv -----
// ----------------------------------------------------------------------------
// Max heap priority queue
// Binary max heap of signed 32-bit keys with insert, remove and extract.
// ----------------------------------------------------------------------------
// The req channel takes one word per operation: insert a key, remove the
// first stored entry equal to a key, or extract the maximum. The rsp channel
// returns exactly one word per operation with the extracted maximum (or -1),
// a status code, the entry count after the operation and an empty flag.
// The heap lives in a RAM with two registered read ports; a single shared
// comparator and a small sequencer do all of the work, one heap level or
// one scanned entry at a time. The moving entry is held in a register and
// written once when it lands, so each level costs one RAM write at most.
// An insert sifts the new key up level by level; an extract reads the root
// and the last entry, then sifts down; a remove scans the stored entries in
// order and then sifts the entry that fills the hole. The sequencer handles
// one word at a time and takes no new request until it is back in idle. The
// result sits in an output register; the next request is accepted while it
// waits, and the sequencer only holds in its final step if an older result
// has still not been taken.
// Reset empties the heap at once; the RAM is not cleared, since only
// entries below the count are ever used.
// ----------------------------------------------------------------------------
module max_heap_priority_queue #(
	parameter int CAPACITY = hpq_pkg::DEF_CAPACITY
) (
	input  logic     clk,
	input  logic     arst_n,
	hpq_req_if.sink  req,
	hpq_rsp_if.source rsp
);

	import hpq_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = CW + 1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN,
		S_EX_RD,
		S_EX_WAIT,
		S_UP_RD,
		S_UP_CMP,
		S_DN_RD,
		S_DN_CMPL,
		S_DN_CMPR,
		S_DONE
	} state_t;

	state_t         state_q;
	logic [CW-1:0]  fill_q;
	op_t            op_q;
	key_t           key_q;
	key_t           mv_q;
	key_t           best_q;
	logic           bchild_q;
	logic           rv_q;
	logic           moved_q;
	logic [AW-1:0]  pos_q;
	logic [CW-1:0]  idx_q;
	logic           chk_q;
	logic [AW-1:0]  cidx_q;
	status_t        status_q;
	key_t           top_q;
	logic           rsp_vld_q;
	key_t           rsp_top_q;
	status_t        rsp_status_q;
	count_t         rsp_count_q;
	logic           rsp_empty_q;

	logic [IW-1:0]  lc;
	logic [IW-1:0]  rc;
	logic [AW-1:0]  par;
	logic [AW-1:0]  last;
	logic           l_ok;
	logic           r_ok;
	logic           more;
	key_t           cmp_a;
	key_t           cmp_b;
	logic           cmp_gt;
	logic           cmp_eq;
	logic           up_stop;
	logic           to_down;
	logic           take_r;
	logic           found;
	logic           accept;
	logic           rsp_free;
	logic           wr_en;
	logic [AW-1:0]  wr_addr;
	key_t           wr_data;
	logic           rd_en_a;
	logic [AW-1:0]  rd_addr_a;
	logic           rd_en_b;
	logic [AW-1:0]  rd_addr_b;
	key_t           rd_a;
	key_t           rd_b;

	// Index arithmetic around the current position.
	assign lc   = (IW'(pos_q) << 1) + IW'(1);
	assign rc   = (IW'(pos_q) << 1) + IW'(2);
	assign par  = AW'((pos_q - AW'(1)) >> 1);
	assign last = AW'(fill_q - CW'(1));
	assign l_ok = (lc < IW'(fill_q));
	assign r_ok = (rc < IW'(fill_q));
	assign more = (idx_q < fill_q);

	assign accept   = req.valid && req.ready;
	assign rsp_free = !rsp_vld_q || rsp.ready;

	// Operand selection for the shared comparator.
	always_comb begin
		case (state_q)
			S_UP_CMP: begin
				cmp_a = mv_q;
				cmp_b = rd_a;
			end
			S_SCAN: begin
				cmp_a = rd_a;
				cmp_b = key_q;
			end
			S_DN_CMPR: begin
				cmp_a = rd_b;
				cmp_b = best_q;
			end
			default: begin
				cmp_a = rd_a;
				cmp_b = mv_q;
			end
		endcase
	end

	hpq_cmp u_cmp (
		.a  (cmp_a),
		.b  (cmp_b),
		.gt (cmp_gt),
		.eq (cmp_eq)
	);

	// A sift up stops at the root or below a parent that is not smaller.
	// For a remove that never moved up, the entry then sifts down instead.
	assign up_stop = ((state_q == S_UP_RD) && (pos_q == '0)) ||
		((state_q == S_UP_CMP) && !cmp_gt);
	assign to_down = up_stop && (op_q == OP_REMOVE) && !moved_q;
	assign take_r  = (state_q == S_DN_CMPR) && rv_q && cmp_gt;
	assign found   = (state_q == S_SCAN) && chk_q && cmp_eq;

	// RAM port control.
	always_comb begin
		rd_en_a   = 1'b0;
		rd_addr_a = '0;
		rd_en_b   = 1'b0;
		rd_addr_b = last;
		wr_en     = 1'b0;
		wr_addr   = pos_q;
		wr_data   = mv_q;
		case (state_q)
			S_SCAN: begin
				rd_en_a   = more && !found;
				rd_addr_a = AW'(idx_q);
				rd_en_b   = 1'b1;
			end
			S_EX_RD: begin
				rd_en_a = 1'b1;
				rd_en_b = 1'b1;
			end
			S_UP_RD: begin
				rd_en_a   = (pos_q != '0);
				rd_addr_a = par;
				wr_en     = up_stop && !to_down;
			end
			S_UP_CMP: begin
				if (cmp_gt) begin
					wr_en   = 1'b1;
					wr_data = rd_a;
				end else begin
					wr_en = !to_down;
				end
			end
			S_DN_RD: begin
				rd_en_a   = l_ok;
				rd_addr_a = AW'(lc);
				rd_en_b   = r_ok;
				rd_addr_b = AW'(rc);
				wr_en     = !l_ok;
			end
			S_DN_CMPR: begin
				wr_en = 1'b1;
				if (take_r) begin
					wr_data = rd_b;
				end else if (bchild_q) begin
					wr_data = best_q;
				end
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	hpq_ram #(
		.WIDTH ($bits(key_t)),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_en_a   (rd_en_a),
		.rd_addr_a (rd_addr_a),
		.rd_data_a (rd_a),
		.rd_en_b   (rd_en_b),
		.rd_addr_b (rd_addr_b),
		.rd_data_b (rd_b)
	);

	// Sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			fill_q       <= '0;
			op_q         <= OP_INSERT;
			key_q        <= '0;
			mv_q         <= '0;
			best_q       <= '0;
			bchild_q     <= 1'b0;
			rv_q         <= 1'b0;
			moved_q      <= 1'b0;
			pos_q        <= '0;
			idx_q        <= '0;
			chk_q        <= 1'b0;
			cidx_q       <= '0;
			status_q     <= ST_OK;
			top_q        <= NO_TOP;
			rsp_vld_q    <= 1'b0;
			rsp_top_q    <= NO_TOP;
			rsp_status_q <= ST_OK;
			rsp_count_q  <= '0;
			rsp_empty_q  <= 1'b1;
		end else begin
			// The final step reloads the output register itself.
			if (rsp_vld_q && rsp.ready && (state_q != S_DONE)) begin
				rsp_vld_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q    <= req.op;
						key_q   <= req.key;
						top_q   <= NO_TOP;
						moved_q <= 1'b0;
						chk_q   <= 1'b0;
						idx_q   <= '0;
						case (req.op)
							OP_INSERT: begin
								if (fill_q == CW'(CAPACITY)) begin
									status_q <= ST_FULL;
									state_q  <= S_DONE;
								end else begin
									status_q <= ST_OK;
									mv_q     <= req.key;
									pos_q    <= AW'(fill_q);
									fill_q   <= fill_q + CW'(1);
									state_q  <= S_UP_RD;
								end
							end
							OP_REMOVE: begin
								status_q <= ST_NOT_FOUND;
								state_q  <= S_SCAN;
							end
							OP_EXTRACT: begin
								if (fill_q == '0) begin
									status_q <= ST_EMPTY;
									state_q  <= S_DONE;
								end else begin
									status_q <= ST_OK;
									state_q  <= S_EX_RD;
								end
							end
							default: begin
								status_q <= ST_OK;
								state_q  <= S_DONE;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (found) begin
						// The last entry fills the hole left by the match.
						status_q <= ST_OK;
						fill_q   <= fill_q - CW'(1);
						mv_q     <= rd_b;
						pos_q    <= cidx_q;
						if (CW'(cidx_q) == fill_q - CW'(1)) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_UP_RD;
						end
					end else begin
						chk_q <= more;
						if (more) begin
							cidx_q <= AW'(idx_q);
							idx_q  <= idx_q + CW'(1);
						end else if (!chk_q) begin
							state_q <= S_DONE;
						end
					end
				end
				S_EX_RD: begin
					fill_q  <= fill_q - CW'(1);
					state_q <= S_EX_WAIT;
				end
				S_EX_WAIT: begin
					top_q   <= rd_a;
					mv_q    <= rd_b;
					pos_q   <= '0;
					state_q <= S_DN_RD;
				end
				S_UP_RD: begin
					if (pos_q == '0) begin
						state_q <= to_down ? S_DN_RD : S_DONE;
					end else begin
						state_q <= S_UP_CMP;
					end
				end
				S_UP_CMP: begin
					if (cmp_gt) begin
						pos_q   <= par;
						moved_q <= 1'b1;
						state_q <= S_UP_RD;
					end else begin
						state_q <= to_down ? S_DN_RD : S_DONE;
					end
				end
				S_DN_RD: begin
					if (!l_ok) begin
						state_q <= S_DONE;
					end else begin
						rv_q    <= r_ok;
						state_q <= S_DN_CMPL;
					end
				end
				S_DN_CMPL: begin
					// Left child against the moving entry.
					if (cmp_gt) begin
						best_q   <= rd_a;
						bchild_q <= 1'b1;
					end else begin
						best_q   <= mv_q;
						bchild_q <= 1'b0;
					end
					state_q <= S_DN_CMPR;
				end
				S_DN_CMPR: begin
					// Right child against the larger of the two; ties keep the left child or the moving entry.
					if (take_r) begin
						pos_q   <= AW'(rc);
						state_q <= S_DN_RD;
					end else if (bchild_q) begin
						pos_q   <= AW'(lc);
						state_q <= S_DN_RD;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (rsp_free) begin
						rsp_vld_q    <= 1'b1;
						rsp_top_q    <= top_q;
						rsp_status_q <= status_q;
						rsp_count_q  <= COUNT_W'(fill_q);
						rsp_empty_q  <= (fill_q == '0);
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req.ready       = (state_q == S_IDLE);
	assign rsp.valid       = rsp_vld_q;
	assign rsp.top_value   = rsp_top_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.entry_count = rsp_count_q;
	assign rsp.is_empty    = rsp_empty_q;

endmodule
